// ----- src/gct_pkg.sv -----
// Shared types, constants and the two-byte glyph table for the glyph code transcoder.
package gct_pkg;

   localparam logic [7:0] GLYPH_UNKNOWN = 8'h3F;
   localparam logic [7:0] GLYPH_DOT     = 8'h2E;
   localparam logic [7:0] LEAD_C3       = 8'hC3;
   localparam logic [7:0] LEAD_C4       = 8'hC4;
   localparam logic [7:0] LEAD_C5       = 8'hC5;
   localparam logic [7:0] DOT_LIMIT     = 8'd3;
   localparam logic [1:0] MAX_RESULTS   = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] glyph_code;
      logic       last_glyph;
   } rsp_payload_type;

   // All result beats caused by one input beat, oldest in entry 0.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] codes;
      logic [2:0]      lasts;
   } bundle_type;

   function automatic logic [7:0] map_pair(input logic [7:0] lead, input logic [7:0] trail);
      logic [7:0] code;
      code = GLYPH_UNKNOWN;
      case (lead)
         LEAD_C4: begin
            case (trail)
               8'h85: code = 8'hB8;
               8'h84: code = 8'hB7;
               8'h87: code = 8'hBD;
               8'h86: code = 8'hC4;
               8'h99: code = 8'hD6;
               8'h98: code = 8'hD7;
               default: code = GLYPH_UNKNOWN;
            endcase
         end
         LEAD_C5: begin
            case (trail)
               8'h82: code = 8'hCF;
               8'h81: code = 8'hD0;
               8'h84: code = 8'hC0;
               8'h83: code = 8'hC1;
               8'h9B: code = 8'hCB;
               8'h9A: code = 8'hCC;
               8'hBA: code = 8'hBB;
               8'hB9: code = 8'hBC;
               8'hBC: code = 8'hB9;
               8'hBB: code = 8'hBA;
               default: code = GLYPH_UNKNOWN;
            endcase
         end
         LEAD_C3: begin
            case (trail)
               8'hB3: code = 8'hBE;
               8'h93: code = 8'hBF;
               default: code = GLYPH_UNKNOWN;
            endcase
         end
         default: code = GLYPH_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// ----- src/utf8_to_glyph_code_transcoder.sv -----
// A released glyph enters the bundle queue as its text beat is taken; rsp offers the queue head.
// Throughput: one text beat per cycle while the queue is not full; the output serializer sends
// one glyph per cycle while rsp_ready is high, so a beat that releases k glyphs (k up to 3, as
// at a truncation) takes k output beats. The bundle queue of QUEUE_DEPTH entries lets input
// continue while output is stalled. Reset is synchronous and active high: it empties the queue,
// clears the string state and sets max_glyphs to 0 (unlimited); held glyph storage is not cleared.
module utf8_to_glyph_code_transcoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  gct_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output gct_pkg::rsp_payload_type rsp_payload
);
   import gct_pkg::*;

   logic       push_valid;
   logic       push_ready;
   bundle_type push_bundle;
   logic       head_valid;
   logic       head_pop;
   bundle_type head_bundle;

   gct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_bundle (push_bundle)
   );

   gct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_bundle (push_bundle),
      .head_valid  (head_valid),
      .head_pop    (head_pop),
      .head_bundle (head_bundle)
   );

   gct_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .head_pop    (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- src/gct_front.sv -----
// Front end: accepts text bytes, decodes them, applies the glyph limit and builds result bundles.
module gct_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gct_pkg::req_payload_type req_payload,
   output logic                   push_valid,
   input  logic                   push_ready,
   output gct_pkg::bundle_type    push_bundle
);
   import gct_pkg::*;

   logic [7:0]      max_glyphs_ff;
   logic            lead_pending_ff, lead_pending_in;
   logic [7:0]      lead_value_ff, lead_value_in;
   logic [7:0]      glyphs_accepted_ff, glyphs_accepted_in;
   logic            cut_flag_ff, cut_flag_in;
   logic [2:0][7:0] held_glyphs_ff, held_glyphs_in;
   logic [1:0]      held_count_ff, held_count_in;

   logic            have;
   logic [7:0]      glyph;
   logic            pop;
   logic [2:0][7:0] shifted;
   logic [1:0]      after_count;
   logic            limit_hit;
   logic            releasable;
   logic            accept;
   logic [7:0]      text_byte;
   logic            eot;
   bundle_type      bundle;

   assign text_byte = req_payload.text_byte;
   assign eot       = req_payload.end_of_text;
   assign limit_hit = (max_glyphs_ff != 8'd0) && (glyphs_accepted_ff >= max_glyphs_ff);
   // The oldest held glyph may go out once it can no longer be replaced by the dots.
   assign releasable = (max_glyphs_ff < DOT_LIMIT) ||
      (({1'b0, glyphs_accepted_ff} + 9'd3 - {7'd0, held_count_ff}) < {1'b0, max_glyphs_ff});

   always_comb begin
      lead_pending_in    = lead_pending_ff;
      lead_value_in      = lead_value_ff;
      glyphs_accepted_in = glyphs_accepted_ff;
      cut_flag_in        = cut_flag_ff;
      held_glyphs_in     = held_glyphs_ff;
      held_count_in      = held_count_ff;
      bundle             = '0;
      have               = 1'b0;
      glyph              = 8'd0;
      pop                = 1'b0;
      shifted            = held_glyphs_ff;
      after_count        = held_count_ff;

      if (cut_flag_ff) begin
         if (eot) begin
            lead_pending_in    = 1'b0;
            lead_value_in      = 8'd0;
            glyphs_accepted_in = 8'd0;
            cut_flag_in        = 1'b0;
            held_count_in      = 2'd0;
         end
      end else begin
         if (lead_pending_ff) begin
            glyph           = map_pair(lead_value_ff, text_byte);
            have            = 1'b1;
            lead_pending_in = 1'b0;
            lead_value_in   = 8'd0;
         end else if (!text_byte[7]) begin
            glyph = text_byte;
            have  = 1'b1;
         end else if (eot) begin
            // A lone lead byte at the end of the string.
            glyph = GLYPH_UNKNOWN;
            have  = 1'b1;
         end else begin
            lead_pending_in = 1'b1;
            lead_value_in   = text_byte;
         end

         if (have) begin
            if (limit_hit) begin
               if (max_glyphs_ff >= DOT_LIMIT) begin
                  bundle.count = MAX_RESULTS;
                  bundle.codes = {GLYPH_DOT, GLYPH_DOT, GLYPH_DOT};
                  bundle.lasts = 3'b100;
               end else begin
                  bundle.count = held_count_ff;
                  bundle.codes = held_glyphs_ff;
                  case (held_count_ff)
                     2'd1:    bundle.lasts = 3'b001;
                     2'd2:    bundle.lasts = 3'b010;
                     2'd3:    bundle.lasts = 3'b100;
                     default: bundle.lasts = 3'b000;
                  endcase
               end
               held_count_in = 2'd0;
               cut_flag_in   = 1'b1;
               if (eot) begin
                  lead_pending_in    = 1'b0;
                  lead_value_in      = 8'd0;
                  glyphs_accepted_in = 8'd0;
                  cut_flag_in        = 1'b0;
               end
            end else begin
               if (eot) begin
                  pop = (held_count_ff == 2'd3);
               end else begin
                  pop = (held_count_ff == 2'd3) || ((held_count_ff != 2'd0) && releasable);
               end
               if (pop) begin
                  shifted[0]  = held_glyphs_ff[1];
                  shifted[1]  = held_glyphs_ff[2];
                  shifted[2]  = held_glyphs_ff[2];
                  after_count = held_count_ff - 2'd1;
               end
               shifted[after_count] = glyph;
               if (glyphs_accepted_ff != 8'hFF) begin
                  glyphs_accepted_in = glyphs_accepted_ff + 8'd1;
               end
               held_glyphs_in = shifted;
               if (eot) begin
                  // Flush everything held, the new glyph last.
                  bundle.count       = after_count + 2'd1;
                  bundle.codes       = shifted;
                  bundle.lasts       = 3'(3'b001 << after_count);
                  lead_pending_in    = 1'b0;
                  lead_value_in      = 8'd0;
                  glyphs_accepted_in = 8'd0;
                  cut_flag_in        = 1'b0;
                  held_count_in      = 2'd0;
               end else begin
                  if (pop) begin
                     bundle.count    = 2'd1;
                     bundle.codes[0] = held_glyphs_ff[0];
                  end
                  held_count_in = after_count + 2'd1;
               end
            end
         end
      end
   end

   assign req_ready   = push_ready;
   assign accept      = req_valid && req_ready;
   assign push_valid  = req_valid && (bundle.count != 2'd0);
   assign push_bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_glyphs_ff      <= 8'd0;
         lead_pending_ff    <= 1'b0;
         lead_value_ff      <= 8'd0;
         glyphs_accepted_ff <= 8'd0;
         cut_flag_ff        <= 1'b0;
         held_count_ff      <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            max_glyphs_ff <= csr_wr_data;
         end
         if (accept) begin
            lead_pending_ff    <= lead_pending_in;
            lead_value_ff      <= lead_value_in;
            glyphs_accepted_ff <= glyphs_accepted_in;
            cut_flag_ff        <= cut_flag_in;
            held_count_ff      <= held_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_glyphs_ff <= held_glyphs_in;
      end
   end

endmodule

// ----- src/gct_queue.sv -----
// Short register queue of result bundles between the front end and the output serializer.
module gct_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  gct_pkg::bundle_type push_bundle,
   output logic                head_valid,
   input  logic                head_pop,
   output gct_pkg::bundle_type head_bundle
);
   import gct_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bundle_type       entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready  = (count_ff != FULL_CNT);
   assign head_valid  = (count_ff != '0);
   assign head_bundle = entries_ff[rd_ptr_ff];
   assign do_push     = push_valid && push_ready;
   assign do_pop      = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

// ----- src/gct_back.sv -----
// Back end: sends the glyphs of the head bundle out one beat at a time.
module gct_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  gct_pkg::bundle_type     head_bundle,
   output logic                    head_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gct_pkg::rsp_payload_type rsp_payload
);
   import gct_pkg::*;

   logic [1:0] index_ff, index_in;
   logic       beat;
   logic       final_beat;

   assign rsp_valid              = head_valid;
   assign rsp_payload.glyph_code = head_bundle.codes[index_ff];
   assign rsp_payload.last_glyph = head_bundle.lasts[index_ff];
   assign beat                   = rsp_valid && rsp_ready;
   assign final_beat             = (index_ff == head_bundle.count - 2'd1);
   assign head_pop               = beat && final_beat;

   always_comb begin
      index_in = index_ff;
      if (beat) begin
         index_in = final_beat ? 2'd0 : index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
      end else begin
         index_ff <= index_in;
      end
   end

endmodule

// ----- dv/tb_utf8_to_glyph_code_transcoder.sv -----
// Self-checking testbench for the UTF-8 to glyph code transcoder.
module tb_utf8_to_glyph_code_transcoder;
   timeunit 1ns;
   timeprecision 1ps;

   import gct_pkg::*;

   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int HOLD_CYCLES   = 120;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASE_BEATS   = 8;
   localparam int PRINT_LIMIT   = 40;

   // Two-byte sequences that have a font code, lead byte in the upper half.
   localparam logic [15:0] POLISH_PAIRS [18] = '{
      16'hC485, 16'hC484, 16'hC487, 16'hC486, 16'hC499, 16'hC498,
      16'hC582, 16'hC581, 16'hC584, 16'hC583, 16'hC59B, 16'hC59A,
      16'hC5BA, 16'hC5B9, 16'hC5BC, 16'hC5BB, 16'hC3B3, 16'hC393
   };

   typedef enum logic [0:0] {
      ROW_TEXT,
      ROW_LIMIT
   } row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [7:0]      text_byte;
      logic            end_of_text;
      logic            known;
      logic [1:0]      n_glyphs;
      logic [2:0][7:0] glyphs;
   } stim_row_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_wr_en;
   logic [7:0]      csr_wr_data;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   stim_row_type    live_row;
   stim_row_type    opening_plan [28];
   rsp_payload_type glyph_expect [$];
   rsp_payload_type fresh_glyphs [$];
   rsp_payload_type want;
   int              fault_count  = 0;
   int              quiet_cycles = 0;
   int              req_calm     = 0;
   int              rsp_calm     = 0;
   logic            hold_request = 1'b0;

   // Predictor state.
   logic [7:0]      glyph_limit;
   logic            str_lead_wait;
   logic [7:0]      str_lead_byte;
   logic [7:0]      str_count;
   logic            str_cut;
   logic [7:0]      hold_buf [3];
   logic [1:0]      hold_n;

   utf8_to_glyph_code_transcoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   function automatic stim_row_type row_beat(input logic [7:0] b, input logic e);
      stim_row_type r;
      r = '0;
      r.kind = ROW_TEXT;
      r.text_byte = b;
      r.end_of_text = e;
      return r;
   endfunction

   function automatic stim_row_type row_known(input logic [7:0] b, input logic e, input int n,
                                              input logic [7:0] g0, input logic [7:0] g1,
                                              input logic [7:0] g2);
      stim_row_type r;
      r = row_beat(b, e);
      r.known = 1'b1;
      r.n_glyphs = 2'(n);
      r.glyphs = {g2, g1, g0};
      return r;
   endfunction

   function automatic stim_row_type row_limit(input logic [7:0] value);
      stim_row_type r;
      r = '0;
      r.kind = ROW_LIMIT;
      r.text_byte = value;
      return r;
   endfunction

   // Mostly zero, sometimes a few cycles, rarely a long gap; now and then a calm run.
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] polish_glyph(input logic [7:0] lead, input logic [7:0] trail);
      case ({lead, trail})
         16'hC485: return 8'hB8;
         16'hC484: return 8'hB7;
         16'hC487: return 8'hBD;
         16'hC486: return 8'hC4;
         16'hC499: return 8'hD6;
         16'hC498: return 8'hD7;
         16'hC582: return 8'hCF;
         16'hC581: return 8'hD0;
         16'hC584: return 8'hC0;
         16'hC583: return 8'hC1;
         16'hC59B: return 8'hCB;
         16'hC59A: return 8'hCC;
         16'hC5BA: return 8'hBB;
         16'hC5B9: return 8'hBC;
         16'hC5BC: return 8'hB9;
         16'hC5BB: return 8'hBA;
         16'hC3B3: return 8'hBE;
         16'hC393: return 8'hBF;
         default:  return GLYPH_UNKNOWN;
      endcase
   endfunction

   function automatic void restart_string();
      str_lead_wait = 1'b0;
      str_lead_byte = '0;
      str_count = '0;
      str_cut = 1'b0;
      hold_n = '0;
   endfunction

   function automatic void add_glyph(input logic [7:0] code, input logic last);
      fresh_glyphs.push_back('{glyph_code: code, last_glyph: last});
   endfunction

   function automatic logic [7:0] take_held();
      logic [7:0] g;
      g = hold_buf[0];
      hold_buf[0] = hold_buf[1];
      hold_buf[1] = hold_buf[2];
      if (hold_n != 0) hold_n--;
      return g;
   endfunction

   function automatic void flush_held();
      logic       is_last;
      logic [7:0] g;
      while (hold_n != 0) begin
         is_last = (hold_n == 1);
         g = take_held();
         add_glyph(g, is_last);
      end
   endfunction

   // Works out the glyphs that one accepted text beat releases, in order.
   function automatic void predict_glyphs(input req_payload_type beat);
      logic       have;
      logic [7:0] code;
      logic       may_release;
      have = 1'b0;
      code = '0;
      if (str_cut) begin
         if (beat.end_of_text) restart_string();
         return;
      end
      if (str_lead_wait) begin
         code = polish_glyph(str_lead_byte, beat.text_byte);
         str_lead_wait = 1'b0;
         str_lead_byte = '0;
         have = 1'b1;
      end else if (!beat.text_byte[7]) begin
         code = beat.text_byte;
         have = 1'b1;
      end else if (beat.end_of_text) begin
         code = GLYPH_UNKNOWN;
         have = 1'b1;
      end else begin
         str_lead_wait = 1'b1;
         str_lead_byte = beat.text_byte;
      end
      if (!have) return;

      if (glyph_limit != 0 && str_count >= glyph_limit) begin
         if (glyph_limit >= DOT_LIMIT) begin
            add_glyph(GLYPH_DOT, 1'b0);
            add_glyph(GLYPH_DOT, 1'b0);
            add_glyph(GLYPH_DOT, 1'b1);
            hold_n = '0;
         end else begin
            flush_held();
         end
         str_cut = 1'b1;
         if (beat.end_of_text) restart_string();
         return;
      end

      // With dots enabled, the last three glyphs below the limit stay held.
      if (!beat.end_of_text) begin
         may_release = (glyph_limit < DOT_LIMIT) ||
                       (int'(str_count) - int'(hold_n) + 3 < int'(glyph_limit));
         if (hold_n == 3 || (hold_n != 0 && may_release)) add_glyph(take_held(), 1'b0);
      end else if (hold_n == 3) begin
         void'(take_held());
      end
      hold_buf[hold_n] = code;
      hold_n++;
      if (str_count != 8'hFF) str_count++;
      if (beat.end_of_text) begin
         flush_held();
         restart_string();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] expected_value);
      // Keep the log short when the block is badly broken.
      if (fault_count < PRINT_LIMIT)
         $display("%0t mismatch: %s, got %02h, expected %02h", $realtime, what, got,
                  expected_value);
      fault_count++;
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (reset) begin
         glyph_limit = '0;
         restart_string();
      end else begin
         if (csr_wr_en) glyph_limit = csr_wr_data;
         if (req_valid && req_ready) begin
            fresh_glyphs.delete();
            predict_glyphs(req_payload);
            if (live_row.known) begin
               for (int i = 0; i < int'(live_row.n_glyphs); i++)
                  glyph_expect.push_back('{glyph_code: live_row.glyphs[i],
                                          last_glyph: i == int'(live_row.n_glyphs) - 1});
            end else begin
               foreach (fresh_glyphs[i]) glyph_expect.push_back(fresh_glyphs[i]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (glyph_expect.size() == 0) begin
               report_mismatch("glyph beat with nothing expected", rsp_payload.glyph_code,
                               8'h00);
            end else begin
               want = glyph_expect.pop_front();
               if (rsp_payload.glyph_code !== want.glyph_code)
                  report_mismatch("glyph_code", rsp_payload.glyph_code, want.glyph_code);
               if (rsp_payload.last_glyph !== want.last_glyph)
                  report_mismatch("last_glyph", 8'(rsp_payload.last_glyph),
                                  8'(want.last_glyph));
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = pick_gap(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_text(input stim_row_type row);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{text_byte: row.text_byte, end_of_text: row.end_of_text};
      live_row <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The predictor pushes on the edge the beat is taken, so the queue is checked only after that edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (glyph_expect.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_string(input int n_chars, inout int beats);
      logic        e;
      int          kind;
      logic [15:0] pair;
      logic [7:0]  lead;
      for (int i = 0; i < n_chars; i++) begin
         e = (i == n_chars - 1);
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            send_text(row_beat(8'($urandom_range(0, 127)), e));
            beats++;
         end else if (kind < 8) begin
            pair = POLISH_PAIRS[$urandom_range(0, 17)];
            send_text(row_beat(pair[15:8], 1'b0));
            send_text(row_beat(pair[7:0], e));
            beats += 2;
         end else if (kind == 9 && e) begin
            send_text(row_beat(8'($urandom_range(128, 255)), 1'b1));
            beats++;
         end else begin
            // Broken pair: a known lead with a stray trail, or any lead at all.
            if ($urandom_range(0, 1)) lead = 8'($urandom_range(int'(LEAD_C3), int'(LEAD_C5)));
            else lead = 8'($urandom_range(128, 255));
            send_text(row_beat(lead, 1'b0));
            send_text(row_beat(8'($urandom_range(0, 255)), e));
            beats += 2;
         end
      end
   endtask

   initial begin
      logic [7:0] phase_limits [7];
      int         beats;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_payload = '0;
      live_row = '0;

      opening_plan = '{
         row_known(8'h41, 1'b1, 1, 8'h41, 8'h00, 8'h00),
         row_known(8'h00, 1'b1, 1, 8'h00, 8'h00, 8'h00),
         row_known(8'h7F, 1'b1, 1, 8'h7F, 8'h00, 8'h00),
         row_known(8'hFF, 1'b1, 1, GLYPH_UNKNOWN, 8'h00, 8'h00),
         row_known(8'hC4, 1'b0, 0, 8'h00, 8'h00, 8'h00),
         row_known(8'h85, 1'b1, 1, 8'hB8, 8'h00, 8'h00),
         row_known(8'hC5, 1'b0, 0, 8'h00, 8'h00, 8'h00),
         row_known(8'hBB, 1'b1, 1, 8'hBA, 8'h00, 8'h00),
         row_known(8'hC3, 1'b0, 0, 8'h00, 8'h00, 8'h00),
         row_known(8'h93, 1'b1, 1, 8'hBF, 8'h00, 8'h00),
         row_known(8'h80, 1'b0, 0, 8'h00, 8'h00, 8'h00),
         row_known(8'h00, 1'b1, 1, GLYPH_UNKNOWN, 8'h00, 8'h00),
         row_beat(8'hC4, 1'b0),
         row_beat(8'hC4, 1'b0),
         row_known(8'hC5, 1'b1, 2, GLYPH_UNKNOWN, GLYPH_UNKNOWN, 8'h00),
         row_beat(8'h41, 1'b0),
         row_beat(8'h42, 1'b0),
         row_limit(8'd2),
         row_known(8'h43, 1'b1, 1, 8'h42, 8'h00, 8'h00),
         row_limit(8'd3),
         row_known(8'h41, 1'b0, 0, 8'h00, 8'h00, 8'h00),
         row_known(8'h42, 1'b0, 0, 8'h00, 8'h00, 8'h00),
         row_known(8'h43, 1'b0, 0, 8'h00, 8'h00, 8'h00),
         row_known(8'h44, 1'b0, 3, GLYPH_DOT, GLYPH_DOT, GLYPH_DOT),
         row_known(8'h45, 1'b1, 0, 8'h00, 8'h00, 8'h00),
         row_limit(8'd1),
         row_beat(8'h51, 1'b0),
         row_known(8'h52, 1'b1, 1, 8'h51, 8'h00, 8'h00)
      };
      phase_limits = '{8'd0, 8'd3, 8'd4, 8'd2, 8'd1, 8'($urandom_range(5, 12)), 8'd255};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         if (opening_plan[i].kind == ROW_LIMIT) write_limit(opening_plan[i].text_byte);
         else send_text(opening_plan[i]);
      end

      foreach (phase_limits[p]) begin
         write_limit(phase_limits[p]);
         if (p == 0) begin
            // The sender keeps going while the result side is held off.
            hold_request = 1'b1;
            req_calm = 150;
         end
         beats = 0;
         while (beats < PHASE_BEATS) send_random_string($urandom_range(1, 12), beats);
      end

      // A string longer than 255 glyphs in unlimited mode, then a limit set mid-string.
      write_limit(8'd0);
      repeat (258) send_text(row_beat(8'($urandom_range(0, 127)), 1'b0));
      write_limit(8'd200);
      send_text(row_beat(8'h5A, 1'b1));

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
